### src/bte_pkg.sv
// Shared types and constants for the beat-triggered envelope phase core.
// Used by the channel interfaces, the controller, the datapath and the divider.
package bte_pkg;

  // Field widths
  localparam int DeltaW   = 17;
  localparam int SpeedW   = 8;
  localparam int LevelW   = 16;
  localparam int TimeW    = 24;
  localparam int RestW    = 23;
  localparam int Q16W     = 16;
  localparam int WaveW    = 14;
  localparam int ArcW     = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  // Shared serial divider: dividend, divisor and quotient widths
  localparam int DivNW = 65;
  localparam int DivDW = 48;
  localparam int DivQW = 17;

  // Constants
  localparam logic [TimeW-1:0]  TimeMax    = 24'hFFFFFF;
  localparam logic [Q16W-1:0]   FullQ16    = 16'hFFFF;
  localparam logic [Q16W-1:0]   SpeedReset = 16'd4096;
  localparam logic [WaveW-1:0]  WaveBase   = 14'd5120;
  localparam logic [WaveW-1:0]  WaveReset  = 14'd6400;
  localparam logic [14:0]       PhaseGain  = 15'd25033;
  localparam logic [17:0]       FiltTauUs  = 18'd150000;
  localparam logic [15:0]       LevelDiv   = 16'd65535;
  localparam logic [14:0]       LevelRound = 15'd32767;

  localparam logic [TimeW-1:0] BuildReset   = 24'd800000;
  localparam logic [TimeW-1:0] HoldReset    = 24'd300000;
  localparam logic [TimeW-1:0] ReleaseReset = 24'd600000;
  localparam logic [RestW-1:0] RestReset    = 23'd200000;

  typedef enum logic [ArcW-1:0] {
    ARC_REST    = 2'd0,
    ARC_BUILD   = 2'd1,
    ARC_HOLD    = 2'd2,
    ARC_RELEASE = 2'd3
  } arc_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BUILD   = 3'd0,
    CFG_HOLD    = 3'd1,
    CFG_RELEASE = 3'd2,
    CFG_REST    = 3'd3,
    CFG_MODE    = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIV_SPEED = 2'd0,
    DIV_RAMP  = 2'd1,
    DIV_WAVE  = 2'd2
  } div_sel_e;

  // Controller -> datapath
  typedef struct packed {
    logic     in_ready;
    logic     latch_in;
    logic     spd_mul;
    logic     div_load;
    div_sel_e div_sel;
    logic     spd_apply;
    logic     trig;
    logic     eval;
    logic     sq_x;
    logic     sq_d;
    logic     ramp_num;
    logic     ramp_apply;
    logic     wave_apply;
    logic     ph_mul;
    logic     ph_add;
    logic     out_load;
  } bte_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_valid;
    logic div_done;
    logic ramp_req;
    logic out_free;
  } bte_sts_t;

endpackage

### src/bte_if.sv
// Valid/ready channel interfaces for the envelope core: frame input, result
// output and register write. Widths come from bte_pkg.
interface bte_in_if;
  logic                         valid;
  logic                         ready;
  logic [bte_pkg::DeltaW-1:0]   delta_us;
  logic [bte_pkg::SpeedW-1:0]   speed;
  logic                         audio_valid;
  logic                         beat;
  logic [bte_pkg::LevelW-1:0]   level;

  modport source (output valid, delta_us, speed, audio_valid, beat, level, input ready);
  modport sink (input valid, delta_us, speed, audio_valid, beat, level, output ready);
endinterface

interface bte_out_if;
  logic                       valid;
  logic                       ready;
  logic [bte_pkg::ArcW-1:0]   arc_state;
  logic [bte_pkg::Q16W-1:0]   intensity;
  logic [bte_pkg::Q16W-1:0]   wave_phase;
  logic [bte_pkg::WaveW-1:0]  wavelength;
  logic [bte_pkg::Q16W-1:0]   smooth_speed;

  modport source (output valid, arc_state, intensity, wave_phase, wavelength, smooth_speed,
                  input ready);
  modport sink (input valid, arc_state, intensity, wave_phase, wavelength, smooth_speed,
                output ready);
endinterface

interface bte_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bte_pkg::CfgIdxW-1:0]   index;
  logic [bte_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/beat_triggered_envelope_phase_core.sv
// Channel   | dir | handshake     | payload
// ----------+-----+---------------+------------------------------------------------
// in_ch     | in  | valid/ready   | delta_us, speed, audio_valid, beat, level
// out_ch    | out | valid/ready   | arc_state, intensity, wave_phase, wavelength,
//           |     |               | smooth_speed
// cfg_ch    | in  | valid/ready   | index, data (ready always high)
//
// Frames are taken one at a time: the next frame is accepted only after the
// current result has been loaded into the output register. Each frame makes
// two or three passes through the serial divider (speed filter, ramp, wavelength);
// the ramp pass runs only when the envelope is on a BUILD or RELEASE ramp.
// Reset is asynchronous and active low; state registers come back at once, no sweep.
// A stalled output holds the next result in its last step, and input waits behind it.
module beat_triggered_envelope_phase_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  bte_in_if.sink    in_ch,
  bte_out_if.source out_ch,
  bte_cfg_if.sink   cfg_ch
);
  import bte_pkg::*;

  bte_cmd_t cmd;
  bte_sts_t sts;

  bte_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  bte_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

endmodule

### src/bte_div.sv
// Restoring divider, one quotient bit per cycle, shared by the speed filter,
// the envelope ramp and the wavelength map. Depends on bte_pkg.
module bte_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic [bte_pkg::DivNW-1:0]  dividend_i,
  input  logic [bte_pkg::DivDW-1:0]  divisor_i,
  output logic                       done_o,
  output logic [bte_pkg::DivQW-1:0]  quotient_o
);
  import bte_pkg::*;

  localparam int CntW = $clog2(DivQW + 1);

  logic [DivDW-1:0] rem_q, rem_d;
  logic [DivDW-1:0] dvs_q;
  logic [DivQW-1:0] quo_q, quo_d;
  logic [CntW-1:0]  cnt_q;
  logic [DivDW:0]   trial;
  logic [DivDW:0]   diff;
  logic             fits;

  // Partial remainder stays below the divisor, so one extra bit covers the trial.
  always_comb begin
    trial = {rem_q, quo_q[DivQW-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = trial >= {1'b0, dvs_q};
    rem_d = fits ? diff[DivDW-1:0] : trial[DivDW-1:0];
    quo_d = {quo_q[DivQW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= CntW'(DivQW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= dividend_i[DivNW-1:DivQW];
      quo_q <= dividend_i[DivQW-1:0];
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = (cnt_q == CntW'(1));
  assign quotient_o = quo_q;

endmodule

### src/bte_ctrl.sv
// Sequencer for one frame: speed filter, trigger, envelope, ramp, wavelength
// and phase steps. Drives bte_cmd_t, reads bte_sts_t from bte_pkg.
module bte_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bte_pkg::bte_sts_t sts_i,
  output bte_pkg::bte_cmd_t cmd_o
);
  import bte_pkg::*;

  typedef enum logic [15:0] {
    ST_IDLE      = 16'h0001,
    ST_SPD_MUL   = 16'h0002,
    ST_SPD_LOAD  = 16'h0004,
    ST_SPD_WAIT  = 16'h0008,
    ST_TRIG      = 16'h0010,
    ST_EVAL      = 16'h0020,
    ST_SQ_X      = 16'h0040,
    ST_SQ_D      = 16'h0080,
    ST_RAMP_NUM  = 16'h0100,
    ST_RAMP_LOAD = 16'h0200,
    ST_RAMP_WAIT = 16'h0400,
    ST_WAVE_LOAD = 16'h0800,
    ST_WAVE_WAIT = 16'h1000,
    ST_PH_MUL    = 16'h2000,
    ST_PH_ADD    = 16'h4000,
    ST_OUT       = 16'h8000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.div_sel = DIV_SPEED;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_SPD_MUL;
        end
      end
      ST_SPD_MUL: begin
        cmd_o.spd_mul = 1'b1;
        state_d       = ST_SPD_LOAD;
      end
      ST_SPD_LOAD: begin
        cmd_o.div_load = 1'b1;
        cmd_o.div_sel  = DIV_SPEED;
        state_d        = ST_SPD_WAIT;
      end
      ST_SPD_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_TRIG;
        end
      end
      ST_TRIG: begin
        cmd_o.spd_apply = 1'b1;
        cmd_o.trig      = 1'b1;
        state_d         = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.ramp_req ? ST_SQ_X : ST_WAVE_LOAD;
      end
      ST_SQ_X: begin
        cmd_o.sq_x = 1'b1;
        state_d    = ST_SQ_D;
      end
      ST_SQ_D: begin
        cmd_o.sq_d = 1'b1;
        state_d    = ST_RAMP_NUM;
      end
      ST_RAMP_NUM: begin
        cmd_o.ramp_num = 1'b1;
        state_d        = ST_RAMP_LOAD;
      end
      ST_RAMP_LOAD: begin
        cmd_o.div_load = 1'b1;
        cmd_o.div_sel  = DIV_RAMP;
        state_d        = ST_RAMP_WAIT;
      end
      ST_RAMP_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_WAVE_LOAD;
        end
      end
      ST_WAVE_LOAD: begin
        cmd_o.ramp_apply = 1'b1;
        cmd_o.div_load   = 1'b1;
        cmd_o.div_sel    = DIV_WAVE;
        state_d          = ST_WAVE_WAIT;
      end
      ST_WAVE_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_PH_MUL;
        end
      end
      ST_PH_MUL: begin
        cmd_o.wave_apply = 1'b1;
        cmd_o.ph_mul     = 1'b1;
        state_d          = ST_PH_ADD;
      end
      ST_PH_ADD: begin
        cmd_o.ph_add = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/bte_dpath.sv
// Datapath: register file, frame latch, envelope state, phase accumulator and
// output register. Instantiates bte_div; uses bte_pkg and the channel interfaces.
module bte_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bte_pkg::bte_cmd_t cmd_i,
  output bte_pkg::bte_sts_t sts_o,
  bte_in_if.sink            in_ch,
  bte_out_if.source         out_ch,
  bte_cfg_if.sink           cfg_ch
);
  import bte_pkg::*;

  // Configuration
  logic [TimeW-1:0] build_q, hold_q, rel_q;
  logic [RestW-1:0] rest_q;
  logic             mode_q;

  // Frame latch
  logic [DeltaW-1:0] dt_q;
  logic              avalid_q, beat_q;
  logic [LevelW-1:0] level_q;
  logic [21:0]       diff_mag_q;
  logic              diff_neg_q;
  logic [22:0]       half_den_q;

  // Envelope and phase state
  arc_e              arc_q;
  logic [TimeW-1:0]  time_q;
  logic [Q16W-1:0]   env_q;
  logic [Q16W-1:0]   phase_q;
  logic [WaveW-1:0]  wave_q;
  logic              prev_beat_q;
  logic [Q16W-1:0]   sf_q;

  // Work registers
  logic [38:0]       prod_q;
  logic [TimeW-1:0]  ramp_x_q, ramp_d_q;
  logic              need_ramp_q;
  logic [47:0]       xx_q, dd_q;
  logic [DivNW-1:0]  num_q;
  logic [30:0]       ph_prod_q;

  // Output register
  logic              out_valid_q;
  arc_e              o_arc_q;
  logic [Q16W-1:0]   o_int_q, o_phase_q, o_speed_q;
  logic [WaveW-1:0]  o_wave_q;

  // Divider
  logic [DivNW-1:0]  div_num;
  logic [DivDW-1:0]  div_dvs;
  logic              div_done;
  logic [DivQW-1:0]  div_quo;

  // Combinational helpers
  logic [19:0]       spd_target;
  logic [21:0]       sf_times50;
  logic [18:0]       den_base;
  logic [17:0]       sf_up;
  logic [17:0]       sf_sum;
  logic [Q16W-1:0]   sf_next;
  logic              trig_fire;
  logic [24:0]       rest_x3;
  logic [TimeW:0]    t_sum;
  logic [TimeW-1:0]  t_sat;
  logic              ramp_req;
  logic [28:0]       wave_num;
  logic [15:0]       level_inv;
  logic [32:0]       ph_scaled;
  logic [33:0]       ph_round;

  // ---------------------------------------------------------------- config
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      build_q <= BuildReset;
      hold_q  <= HoldReset;
      rel_q   <= ReleaseReset;
      rest_q  <= RestReset;
      mode_q  <= 1'b1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_e'(cfg_ch.index))
        CFG_BUILD:   build_q <= cfg_ch.data;
        CFG_HOLD:    hold_q  <= cfg_ch.data;
        CFG_RELEASE: rel_q   <= cfg_ch.data;
        CFG_REST:    rest_q  <= cfg_ch.data[RestW-1:0];
        CFG_MODE:    mode_q  <= cfg_ch.data[0];
        default: begin
          // unused index: drop the write
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- input
  assign in_ch.ready = cmd_i.in_ready;

  always_comb begin
    spd_target = {in_ch.speed, 12'b0};
    sf_times50 = {1'b0, sf_q, 5'b0} + {2'b0, sf_q, 4'b0} + {5'b0, sf_q, 1'b0};
    den_base   = {1'b0, FiltTauUs} + {2'b0, in_ch.delta_us};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      dt_q       <= in_ch.delta_us;
      avalid_q   <= in_ch.audio_valid;
      beat_q     <= in_ch.beat;
      level_q    <= in_ch.level;
      diff_neg_q <= {2'b0, spd_target} < sf_times50;
      diff_mag_q <= ({2'b0, spd_target} < sf_times50) ? sf_times50 - {2'b0, spd_target}
                                                      : {2'b0, spd_target} - sf_times50;
      // half of 50 * (150000 + dt)
      half_den_q <= {den_base, 4'b0} + {1'b0, den_base, 3'b0} + {4'b0, den_base};
    end
    if (cmd_i.spd_mul) begin
      prod_q <= 39'(diff_mag_q) * 39'(dt_q);
    end
  end

  // ---------------------------------------------------------------- divider
  always_comb begin
    level_inv = ~level_q;
    wave_num  = {1'b0, level_inv, 12'b0} + {3'b0, level_inv, 10'b0} + {14'b0, LevelRound};
    unique case (cmd_i.div_sel)
      DIV_SPEED: begin
        div_num = DivNW'(prod_q) + DivNW'(half_den_q);
        div_dvs = DivDW'({half_den_q, 1'b0});
      end
      DIV_RAMP: begin
        div_num = num_q;
        div_dvs = dd_q;
      end
      DIV_WAVE: begin
        div_num = DivNW'(wave_num);
        div_dvs = DivDW'(LevelDiv);
      end
      default: begin
        div_num = '0;
        div_dvs = '1;
      end
    endcase
  end

  bte_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (cmd_i.div_load),
    .dividend_i (div_num),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // ---------------------------------------------------------------- speed, trigger, envelope
  always_comb begin
    sf_up  = {2'b0, sf_q} + {1'b0, div_quo};
    sf_sum = {2'b0, sf_q} - {1'b0, div_quo};
    if (diff_neg_q) begin
      sf_next = ({1'b0, sf_q} < div_quo) ? '0 : sf_sum[Q16W-1:0];
    end else begin
      sf_next = (sf_up > 18'(FullQ16)) ? FullQ16 : sf_up[Q16W-1:0];
    end

    rest_x3 = {1'b0, rest_q, 1'b0} + {2'b0, rest_q};
    if (mode_q) begin
      trig_fire = avalid_q && beat_q && !prev_beat_q && (arc_q == ARC_REST) &&
                  (time_q >= TimeW'(rest_q));
    end else begin
      trig_fire = (arc_q == ARC_REST) && ({1'b0, time_q} >= rest_x3);
    end

    t_sum    = {1'b0, time_q} + (TimeW+1)'(dt_q);
    t_sat    = t_sum[TimeW] ? TimeMax : t_sum[TimeW-1:0];
    ramp_req = ((arc_q == ARC_BUILD) && (t_sat < build_q)) ||
               ((arc_q == ARC_RELEASE) && (t_sat < rel_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arc_q       <= ARC_REST;
      time_q      <= '0;
      env_q       <= '0;
      phase_q     <= '0;
      wave_q      <= WaveReset;
      prev_beat_q <= 1'b0;
      sf_q        <= SpeedReset;
      need_ramp_q <= 1'b0;
    end else begin
      if (cmd_i.spd_apply) begin
        sf_q <= sf_next;
      end
      if (cmd_i.trig) begin
        if (trig_fire) begin
          arc_q  <= ARC_BUILD;
          time_q <= '0;
        end
        if (mode_q && avalid_q) begin
          prev_beat_q <= beat_q;
        end
      end
      if (cmd_i.eval) begin
        need_ramp_q <= ramp_req;
        time_q      <= t_sat;
        unique case (arc_q)
          ARC_REST: begin
            env_q <= '0;
          end
          ARC_BUILD: begin
            if (!ramp_req) begin
              env_q  <= FullQ16;
              arc_q  <= ARC_HOLD;
              time_q <= '0;
            end
          end
          ARC_HOLD: begin
            env_q <= FullQ16;
            if (t_sat >= hold_q) begin
              arc_q  <= ARC_RELEASE;
              time_q <= '0;
            end
          end
          ARC_RELEASE: begin
            if (!ramp_req) begin
              env_q  <= '0;
              arc_q  <= ARC_REST;
              time_q <= '0;
            end
          end
          default: begin
            arc_q <= ARC_REST;
          end
        endcase
      end
      if (cmd_i.ramp_apply && need_ramp_q) begin
        env_q <= div_quo[Q16W-1:0];
      end
      if (cmd_i.wave_apply && mode_q && avalid_q) begin
        wave_q <= WaveBase + WaveW'(div_quo);
      end
      if (cmd_i.ph_add) begin
        phase_q <= phase_q + ph_round[Q16W+16:17];
      end
    end
  end

  // ---------------------------------------------------------------- ramp and phase work
  always_comb begin
    ph_scaled = (arc_q == ARC_HOLD) ? {2'b0, ph_prod_q} + {1'b0, ph_prod_q, 1'b0}
                                    : {1'b0, ph_prod_q, 1'b0};
    ph_round  = {1'b0, ph_scaled} + 34'd65536;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      ramp_x_q <= (arc_q == ARC_RELEASE) ? rel_q - t_sat : t_sat;
      ramp_d_q <= (arc_q == ARC_RELEASE) ? rel_q : build_q;
    end
    if (cmd_i.sq_x) begin
      xx_q <= 48'(ramp_x_q) * 48'(ramp_x_q);
    end
    if (cmd_i.sq_d) begin
      dd_q <= 48'(ramp_d_q) * 48'(ramp_d_q);
    end
    if (cmd_i.ramp_num) begin
      // 65535 * x^2 + d^2 / 2
      num_q <= {1'b0, xx_q, 16'b0} - DivNW'(xx_q) + DivNW'(dd_q[47:1]);
    end
    if (cmd_i.ph_mul) begin
      ph_prod_q <= 31'(sf_q) * 31'(PhaseGain);
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      o_arc_q   <= arc_q;
      o_int_q   <= env_q;
      o_phase_q <= phase_q;
      o_wave_q  <= wave_q;
      o_speed_q <= sf_q;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.arc_state    = o_arc_q;
  assign out_ch.intensity    = o_int_q;
  assign out_ch.wave_phase   = o_phase_q;
  assign out_ch.wavelength   = o_wave_q;
  assign out_ch.smooth_speed = o_speed_q;

  assign sts_o.in_valid = in_ch.valid;
  assign sts_o.div_done = div_done;
  assign sts_o.ramp_req = ramp_req;
  assign sts_o.out_free = !out_valid_q || out_ch.ready;

endmodule

### src/bte_checker.sv
// Port-level checks for the envelope core, attached to the top level by bind.
// Depends on bte_pkg and the channel interfaces seen through the top's ports.
module bte_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [bte_pkg::ArcW-1:0]    arc_state_i,
  input logic [bte_pkg::Q16W-1:0]    intensity_i,
  input logic [bte_pkg::Q16W-1:0]    wave_phase_i,
  input logic [bte_pkg::WaveW-1:0]   wavelength_i
);
  import bte_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(intensity_i) &&
    $stable(wave_phase_i) && $stable(arc_state_i))
    else $error("result changed while stalled");

  // one frame at a time
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("frame accepted while busy");

  a_rest_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (arc_state_i == ARC_REST) |-> intensity_i == '0)
    else $error("nonzero intensity in rest");

  a_hold_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (arc_state_i == ARC_HOLD) |-> intensity_i == FullQ16)
    else $error("hold not at full intensity");

  a_wave_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (wavelength_i >= WaveBase) && (wavelength_i <= 14'd10240))
    else $error("wavelength out of range");

endmodule

bind beat_triggered_envelope_phase_core bte_checker u_bte_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .arc_state_i  (out_ch.arc_state),
  .intensity_i  (out_ch.intensity),
  .wave_phase_i (out_ch.wave_phase),
  .wavelength_i (out_ch.wavelength)
);
